// ----- rtl/fifo_demand_paging_mmu_unit_macros.svh -----
// Assertion macros for the demand-paging translator.
// Used by the top level; needs nothing else.
`ifndef FIFO_DEMAND_PAGING_MMU_UNIT_MACROS_SVH
`define FIFO_DEMAND_PAGING_MMU_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define FDP_ASSERT_IMPL(LBL, CLK, RSTN, ANT, CON) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |-> (CON)) \
    else $error("fdp: same-cycle check failed");

// next-cycle implication, off during reset
`define FDP_ASSERT_NEXT(LBL, CLK, RSTN, ANT, CON) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |=> (CON)) \
    else $error("fdp: next-cycle check failed");

`endif

// ----- rtl/fdp_pkg.sv -----
// Shared types and codes of the demand-paging translator.
// No dependencies; imported by every module of the block.
package fdp_pkg;

  localparam int ADDR_W     = 16;
  localparam int IDX_W      = 6;
  localparam int VAL_W      = 16;
  localparam int BLK_OUT_W  = 16;
  localparam int CFG_W      = 7;
  localparam int CFG_ADDR_W = 3;
  localparam int APB_W      = 32;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_DISK  = 2'd2;
  localparam logic [1:0] OP_LOAD  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FAULT = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic REG_PAGE_COUNT  = 1'b0;
  localparam logic REG_FRAME_COUNT = 1'b1;

  typedef struct packed {
    logic cap;   // latch the accepted transaction
    logic rd_a;  // read tables at frame / page of the transaction
    logic rd_b;  // read tables at the victim page
    logic upd;   // commit table updates, produce result
  } cmd_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [ADDR_W-1:0]    phys;
    logic [IDX_W-1:0]     vpage;
    logic                 vdirty;
    logic [BLK_OUT_W-1:0] wblk;
    logic [BLK_OUT_W-1:0] fblk;
  } res_t;

endpackage

// ----- rtl/fifo_demand_paging_mmu_unit.sv -----
// Top level of the FIFO demand-paging translator: APB registers, output stage.
// Depends on fdp_pkg, fdp_ctrl, fdp_datapath and the assertion macro header.
`include "fifo_demand_paging_mmu_unit_macros.svh"

// A transaction is latched at its accepting edge; state RDA then reads the
// frame table and the page's entry, state RDB reads the victim page's entry
// and state UPD updates the tables and loads the result into the output
// register. The next transaction is taken in the cycle after the update, so
// one transaction at a time is in flight; a result that sits untaken in the
// output register holds the update step.
// The sequence is set by the single read port of each table memory. Tables
// need no clearing pass: valid bits reset at once. The user must write
// page_count and frame_count only while the block is idle; it is not enforced.
module fifo_demand_paging_mmu_unit import fdp_pkg::*; #(
  parameter int MAX_PAGES       = 64,
  parameter int OFFSET_BITS     = 10,
  parameter int DISK_BLOCK_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_opcode,
  input  logic [ADDR_W-1:0]     in_logical_address,
  input  logic [IDX_W-1:0]      in_entry_index,
  input  logic [VAL_W-1:0]      in_entry_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [ADDR_W-1:0]     out_physical_address,
  output logic [IDX_W-1:0]      out_victim_page,
  output logic                  out_victim_dirty,
  output logic [BLK_OUT_W-1:0]  out_writeback_block,
  output logic [BLK_OUT_W-1:0]  out_fetch_block,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]      pwdata,
  output logic [APB_W-1:0]      prdata,
  output logic                  pready
);

  cmd_t             cmd;
  res_t             res, out_res_r;
  logic             out_valid_r, out_free;
  logic [CFG_W-1:0] page_count_r, frame_count_r;

  assign pready   = 1'b1;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_count_r  <= CFG_W'(64);
      frame_count_r <= CFG_W'(64);
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_PAGE_COUNT:  page_count_r  <= pwdata[CFG_W-1:0];
        REG_FRAME_COUNT: frame_count_r <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PAGE_COUNT:  prdata = APB_W'(page_count_r);
      REG_FRAME_COUNT: prdata = APB_W'(frame_count_r);
      default:         prdata = '0;
    endcase
  end

  fdp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_free (out_free),
    .cmd      (cmd)
  );

  fdp_datapath #(
    .MAX_PAGES       (MAX_PAGES),
    .OFFSET_BITS     (OFFSET_BITS),
    .DISK_BLOCK_BITS (DISK_BLOCK_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .page_count         (page_count_r),
    .frame_count        (frame_count_r),
    .in_opcode          (in_opcode),
    .in_logical_address (in_logical_address),
    .in_entry_index     (in_entry_index),
    .in_entry_value     (in_entry_value),
    .res                (res)
  );

  // output register: loads only when empty or being taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.upd) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) out_res_r <= res;
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_res_r.status;
  assign out_physical_address = out_res_r.phys;
  assign out_victim_page      = out_res_r.vpage;
  assign out_victim_dirty     = out_res_r.vdirty;
  assign out_writeback_block  = out_res_r.wblk;
  assign out_fetch_block      = out_res_r.fblk;

  `FDP_ASSERT_IMPL(a_no_cap_during_upd, clk, rst_n, in_valid && !in_stall, !cmd.upd)
  `FDP_ASSERT_NEXT(a_upd_gives_result, clk, rst_n, cmd.upd, out_valid)
  `FDP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

endmodule

// ----- rtl/fdp_ctrl.sv -----
// Sequencer of the demand-paging translator: accept, two table reads, update.
// Depends on fdp_pkg.
module fdp_ctrl import fdp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic out_free,
  output cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RDA  = 2'd1;
  localparam logic [1:0] S_RDB  = 2'd2;
  localparam logic [1:0] S_UPD  = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd.cap  = in_valid && (state_r == S_IDLE);
    cmd.rd_a = (state_r == S_RDA);
    cmd.rd_b = (state_r == S_RDB);
    cmd.upd  = (state_r == S_UPD) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_RDA;
      S_RDA:  state_nxt = S_RDB;
      S_RDB:  state_nxt = S_UPD;
      S_UPD:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/fdp_datapath.sv -----
// Page tables, frame table, FIFO pointer and translation logic.
// Depends on fdp_pkg; driven by the command struct of fdp_ctrl.
module fdp_datapath import fdp_pkg::*; #(
  parameter int MAX_PAGES       = 64,
  parameter int OFFSET_BITS     = 10,
  parameter int DISK_BLOCK_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  logic [CFG_W-1:0]  page_count,
  input  logic [CFG_W-1:0]  frame_count,
  input  logic [1:0]        in_opcode,
  input  logic [ADDR_W-1:0] in_logical_address,
  input  logic [IDX_W-1:0]  in_entry_index,
  input  logic [VAL_W-1:0]  in_entry_value,
  output res_t              res
);

  localparam int PAGE_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int IW     = (PAGE_W > IDX_W) ? PAGE_W : IDX_W;
  localparam int CMP_W  = (PAGE_W + 1 > CFG_W) ? PAGE_W + 1 : CFG_W;
  localparam int LA_W   = ADDR_W + 1;
  localparam int BW     = DISK_BLOCK_BITS;
  localparam logic [ADDR_W-1:0] OFS_MASK = ADDR_W'((64'd1 << OFFSET_BITS) - 64'd1);

  // captured transaction
  logic [1:0]        op_r;
  logic [ADDR_W-1:0] la_r;
  logic [IDX_W-1:0]  idx_r;
  logic [VAL_W-1:0]  val_r;

  // tables
  logic [PAGE_W-1:0] pf_mem_r [MAX_PAGES];  // page -> frame
  logic [PAGE_W-1:0] fp_mem_r [MAX_PAGES];  // frame -> page
  logic [BW-1:0]     db_mem_r [MAX_PAGES];  // page -> disk block
  logic [MAX_PAGES-1:0] page_valid_r, page_dirty_r, fp_vld_r;
  logic [MAX_PAGES-1:0] page_valid_nxt, page_dirty_nxt;
  logic [PAGE_W-1:0] ptr_r, ptr_nxt;

  // registered read data
  logic [PAGE_W-1:0] fp_rd_r, pf_pg_r, pf_old_r;
  logic              fpv_rd_r;
  logic [BW-1:0]     db_pg_r, db_old_r;

  logic [LA_W-1:0]   la_page;
  logic [ADDR_W-1:0] ofs;
  logic              acc_oor, is_acc, hit, fault, setld, setdb, mapped, acc_ok;
  logic [PAGE_W-1:0] acc_pg, idx_p, vpg_p, tgt_pg, sel_fr, old_pg, raddr, frame_out;
  logic [IW-1:0]     idx_ext, vpg_ext;
  logic              idx_ok, vpg_ok;
  logic [CMP_W-1:0]  fr1, fc, fiu;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r  <= in_opcode;
      la_r  <= in_logical_address;
      idx_r <= in_entry_index;
      val_r <= in_entry_value;
    end
  end

  always_comb begin
    la_page = {1'b0, la_r} >> OFFSET_BITS;
    ofs     = la_r & OFS_MASK;
    acc_oor = (la_page >= LA_W'(page_count)) || (la_page >= LA_W'(MAX_PAGES));
    acc_pg  = la_page[PAGE_W-1:0];
    idx_ext = IW'(idx_r);
    vpg_ext = IW'(val_r[IDX_W-1:0]);
    idx_ok  = {1'b0, idx_ext} < (IW + 1)'(MAX_PAGES);
    vpg_ok  = {1'b0, vpg_ext} < (IW + 1)'(MAX_PAGES);
    idx_p   = idx_ext[PAGE_W-1:0];
    vpg_p   = vpg_ext[PAGE_W-1:0];
    is_acc  = (op_r == OP_READ) || (op_r == OP_WRITE);
    tgt_pg  = is_acc ? acc_pg : vpg_p;
    sel_fr  = is_acc ? ptr_r : idx_p;
    // an unloaded frame holds page zero
    old_pg  = fpv_rd_r ? fp_rd_r : '0;
    raddr   = cmd.rd_a ? tgt_pg : old_pg;

    hit     = page_valid_r[acc_pg];
    acc_ok  = is_acc && !acc_oor;
    fault   = acc_ok && !hit;
    setld   = (op_r == OP_LOAD) && idx_ok && vpg_ok;
    setdb   = (op_r == OP_DISK) && idx_ok;
    // victim counts only if its entry still points at this frame
    mapped  = page_valid_r[old_pg] && (pf_old_r == sel_fr);
    frame_out = hit ? pf_pg_r : sel_fr;

    fr1 = CMP_W'(ptr_r) + CMP_W'(1);
    fc  = CMP_W'(frame_count);
    if (fc == '0) begin
      fiu = CMP_W'(1);
    end else if (fc > CMP_W'(MAX_PAGES)) begin
      fiu = CMP_W'(MAX_PAGES);
    end else begin
      fiu = fc;
    end
    ptr_nxt = (fr1 >= fiu) ? '0 : fr1[PAGE_W-1:0];
  end

  always_comb begin
    res = '0;
    if (acc_oor && is_acc) begin
      res.status = ST_RANGE;
    end else if (fault) begin
      res.status = ST_FAULT;
    end else begin
      res.status = ST_OK;
    end
    if (acc_ok) begin
      res.phys = ADDR_W'((32'(frame_out) << OFFSET_BITS) + 32'(ofs));
    end
    if (fault) begin
      res.vpage = IDX_W'(old_pg);
      res.fblk  = BLK_OUT_W'(db_pg_r);
      if (mapped && page_dirty_r[old_pg]) begin
        res.vdirty = 1'b1;
        res.wblk   = BLK_OUT_W'(db_old_r);
      end
    end
  end

  always_comb begin
    page_valid_nxt = page_valid_r;
    page_dirty_nxt = page_dirty_r;
    if (cmd.upd) begin
      if ((fault || setld) && mapped) begin
        page_valid_nxt[old_pg] = 1'b0;
        page_dirty_nxt[old_pg] = 1'b0;
      end
      // new mapping overrides the invalidation when the pages coincide
      if (fault || setld) begin
        page_valid_nxt[tgt_pg] = 1'b1;
        page_dirty_nxt[tgt_pg] = fault && (op_r == OP_WRITE);
      end
      if (acc_ok && hit && (op_r == OP_WRITE)) page_dirty_nxt[acc_pg] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd && (fault || setld)) pf_mem_r[tgt_pg] <= sel_fr;
    if (cmd.rd_a) pf_pg_r  <= pf_mem_r[raddr];
    if (cmd.rd_b) pf_old_r <= pf_mem_r[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.upd && setdb) db_mem_r[idx_p] <= BW'(val_r);
    if (cmd.rd_a) db_pg_r  <= db_mem_r[raddr];
    if (cmd.rd_b) db_old_r <= db_mem_r[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.upd && (fault || setld)) fp_mem_r[sel_fr] <= tgt_pg;
    if (cmd.rd_a) fp_rd_r <= fp_mem_r[sel_fr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_valid_r <= '0;
      page_dirty_r <= '0;
      fp_vld_r     <= '0;
      ptr_r        <= '0;
      fpv_rd_r     <= 1'b0;
    end else begin
      page_valid_r <= page_valid_nxt;
      page_dirty_r <= page_dirty_nxt;
      if (cmd.rd_a) fpv_rd_r <= fp_vld_r[sel_fr];
      if (cmd.upd) begin
        if (fault || setld) fp_vld_r[sel_fr] <= 1'b1;
        if (fault) ptr_r <= ptr_nxt;
      end
    end
  end

endmodule

// ----- sim/fifo_demand_paging_mmu_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for fifo_demand_paging_mmu_unit: a directed stimulus table, then
// random phases over several page/frame counts, checked against a local translator model.
// Depends on fdp_pkg and the fifo_demand_paging_mmu_unit RTL.
module fifo_demand_paging_mmu_unit_test;
  import fdp_pkg::*;

  localparam int NPAGES      = 64;
  localparam int OFS_W       = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 8;
  localparam int HOLD_LEN    = 300;
  localparam int DIR_ROWS    = 24;
  localparam res_t NO_RES    = '0;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CHECK, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [1:0]        op;
    logic [ADDR_W-1:0] addr;
    logic [IDX_W-1:0]  idx;
    logic [VAL_W-1:0]  val;
    logic              cfg_reg;
    res_t              want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_opcode = OP_READ;
  logic [ADDR_W-1:0]     in_logical_address = '0;
  logic [IDX_W-1:0]      in_entry_index = '0;
  logic [VAL_W-1:0]      in_entry_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_status;
  logic [ADDR_W-1:0]     out_physical_address;
  logic [IDX_W-1:0]      out_victim_page;
  logic                  out_victim_dirty;
  logic [BLK_OUT_W-1:0]  out_writeback_block;
  logic [BLK_OUT_W-1:0]  out_fetch_block;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [APB_W-1:0]      pwdata = '0;
  logic [APB_W-1:0]      prdata;
  logic                  pready;

  // translator model state
  logic             pg_valid [NPAGES];
  logic             pg_dirty [NPAGES];
  logic [IDX_W-1:0] pg_frame [NPAGES];
  logic [VAL_W-1:0] pg_block [NPAGES];
  logic [IDX_W-1:0] frame_owner [NPAGES];
  logic [IDX_W-1:0] fifo_ptr = '0;
  logic [CFG_W-1:0] page_limit = 7'd64;
  logic [CFG_W-1:0] frame_limit = 7'd64;

  bit          block_known [NPAGES];
  res_t        pending_xlat [$];
  int          errors = 0;
  int          checked = 0;
  int          cycles = 0;
  int unsigned send_idle = 14;
  int unsigned recv_idle = 68;
  int          hold_left = 0;
  logic        hold_req = 1'b0;
  logic        hold_ack = 1'b0;

  fifo_demand_paging_mmu_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_opcode            (in_opcode),
    .in_logical_address   (in_logical_address),
    .in_entry_index       (in_entry_index),
    .in_entry_value       (in_entry_value),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_physical_address (out_physical_address),
    .out_victim_page      (out_victim_page),
    .out_victim_dirty     (out_victim_dirty),
    .out_writeback_block  (out_writeback_block),
    .out_fetch_block      (out_fetch_block),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("fifo_demand_paging_mmu_unit: mismatch");
      $finish;
    end
  end

  // Applies one transaction to the model tables and returns the translation result.
  function automatic res_t translate(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                                     input logic [IDX_W-1:0] idx,
                                     input logic [VAL_W-1:0] val);
    res_t             r;
    logic [IDX_W-1:0] pg;
    logic [IDX_W-1:0] fr;
    logic [IDX_W-1:0] old;
    int               nfr;
    r = '0;
    case (op)
      OP_DISK: pg_block[idx] = val;
      OP_LOAD: begin
        pg  = val[IDX_W-1:0];
        old = frame_owner[idx];
        if (pg_valid[old] && pg_frame[old] == idx) begin
          pg_valid[old] = 1'b0;
          pg_dirty[old] = 1'b0;
        end
        frame_owner[idx] = pg;
        pg_valid[pg] = 1'b1;
        pg_dirty[pg] = 1'b0;
        pg_frame[pg] = idx;
      end
      default: begin
        pg = addr[ADDR_W-1:OFS_W];
        if ({1'b0, pg} >= page_limit) begin
          r.status = ST_RANGE;
        end else begin
          if (!pg_valid[pg]) begin
            fr  = fifo_ptr;
            old = frame_owner[fr];
            r.status = ST_FAULT;
            r.vpage  = old;
            // stale frame entry: page moved or dropped, nothing to invalidate
            if (pg_valid[old] && pg_frame[old] == fr) begin
              if (pg_dirty[old]) begin
                r.vdirty = 1'b1;
                r.wblk   = pg_block[old];
              end
              pg_valid[old] = 1'b0;
              pg_dirty[old] = 1'b0;
            end
            r.fblk = pg_block[pg];
            frame_owner[fr] = pg;
            pg_frame[pg] = fr;
            pg_valid[pg] = 1'b1;
            pg_dirty[pg] = 1'b0;
            nfr = (frame_limit == '0) ? 1 :
                  (int'(frame_limit) > NPAGES) ? NPAGES : int'(frame_limit);
            fifo_ptr = (int'(fr) + 1 >= nfr) ? '0 : fr + 1'b1;
          end
          r.phys = {pg_frame[pg], addr[OFS_W-1:0]};
          if (op == OP_WRITE) pg_dirty[pg] = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (errors < 40)
      $display("translation %0d: %s got 0x%0h want 0x%0h", checked, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_xlat.size() == 0) begin
        flag_mismatch("result with nothing pending", 32'(out_status), '0);
      end else begin
        want = pending_xlat.pop_front();
        if (out_status !== want.status)
          flag_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_physical_address !== want.phys)
          flag_mismatch("physical_address", 32'(out_physical_address), 32'(want.phys));
        if (out_victim_page !== want.vpage)
          flag_mismatch("victim_page", 32'(out_victim_page), 32'(want.vpage));
        if (out_victim_dirty !== want.vdirty)
          flag_mismatch("victim_dirty", 32'(out_victim_dirty), 32'(want.vdirty));
        if (out_writeback_block !== want.wblk)
          flag_mismatch("writeback_block", 32'(out_writeback_block), 32'(want.wblk));
        if (out_fetch_block !== want.fblk)
          flag_mismatch("fetch_block", 32'(out_fetch_block), 32'(want.fblk));
      end
      checked++;
    end
  end

  // result side: random stall, or a long hold-off when the stimulus asks for one
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // Offers one transaction; returns at the edge where it was taken, valid still high.
  task automatic send_item(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                           input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val,
                           input bit typed, input res_t want);
    res_t r;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_opcode          <= op;
    in_logical_address <= addr;
    in_entry_index     <= idx;
    in_entry_value     <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_DISK) block_known[idx] = 1'b1;
    r = translate(op, addr, idx, val);
    pending_xlat.push_back(typed ? want : r);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_xlat.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic sel, input logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {25'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_PAGE_COUNT) page_limit = value;
    else frame_limit = value;
    @(posedge clk);
  endtask

  // Sets both count registers, then n random transactions biased toward pages 0..span.
  task automatic run_phase(input logic [CFG_W-1:0] pages, input logic [CFG_W-1:0] frames,
                           input int n, input int span, input int pause_at,
                           input int hold_at);
    logic [1:0]       op;
    logic [IDX_W-1:0] pg;
    logic [IDX_W-1:0] idx;
    logic [OFS_W-1:0] ofs;
    logic [VAL_W-1:0] val;
    int               pick;
    drain;
    cfg_write(REG_PAGE_COUNT, pages);
    cfg_write(REG_FRAME_COUNT, frames);
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) drain;
      if (i == hold_at) hold_req <= ~hold_req;
      pick = $urandom_range(99);
      op = (pick < 36) ? OP_READ : (pick < 72) ? OP_WRITE : (pick < 86) ? OP_DISK : OP_LOAD;
      pg  = ($urandom_range(9) < 7) ? IDX_W'($urandom_range(span)) : IDX_W'($urandom);
      idx = ($urandom_range(3) != 0) ? IDX_W'($urandom_range(span)) : IDX_W'($urandom);
      case ($urandom_range(9))
        0:       ofs = '0;
        1:       ofs = '1;
        default: ofs = OFS_W'($urandom);
      endcase
      val = VAL_W'($urandom);
      // never let a fault or writeback touch a disk block that was never set
      if (op != OP_DISK && !block_known[pg])
        send_item(OP_DISK, ADDR_W'($urandom), pg, VAL_W'($urandom), 1'b0, NO_RES);
      if (op == OP_LOAD) val[IDX_W-1:0] = pg;
      send_item(op, {pg, ofs}, idx, val, 1'b0, NO_RES);
    end
  endtask

  initial begin : stimulus
    stim_row_t dir_tab [DIR_ROWS];
    for (int p = 0; p < NPAGES; p++) begin
      pg_valid[p]    = 1'b0;
      pg_dirty[p]    = 1'b0;
      pg_frame[p]    = '0;
      pg_block[p]    = '0;
      frame_owner[p] = '0;
      block_known[p] = 1'b0;
    end

    dir_tab[0]  = '{ROW_CHECK, OP_DISK, 16'h0000, 6'd0, 16'hA5A5, 1'b0, NO_RES};
    dir_tab[1]  = '{ROW_CHECK, OP_DISK, 16'h0000, 6'd63, 16'hFFFF, 1'b0, NO_RES};
    dir_tab[2]  = '{ROW_CHECK, OP_DISK, 16'h0000, 6'd5, 16'h1234, 1'b0, NO_RES};
    dir_tab[3]  = '{ROW_CHECK, OP_DISK, 16'h0000, 6'd1, 16'h0000, 1'b0, NO_RES};
    dir_tab[4]  = '{ROW_CHECK, OP_DISK, 16'h0000, 6'd7, 16'hBEEF, 1'b0, NO_RES};
    // first fault: frame 0 records page 0, which is not resident yet
    dir_tab[5]  = '{ROW_CHECK, OP_READ, 16'h0000, 6'd0, 16'h0000, 1'b0,
                    '{ST_FAULT, 16'h0000, 6'd0, 1'b0, 16'h0000, 16'hA5A5}};
    dir_tab[6]  = '{ROW_CHECK, OP_WRITE, 16'h03FF, 6'd0, 16'h0000, 1'b0,
                    '{ST_OK, 16'h03FF, 6'd0, 1'b0, 16'h0000, 16'h0000}};
    dir_tab[7]  = '{ROW_CHECK, OP_READ, 16'hFFFF, 6'd0, 16'h0000, 1'b0,
                    '{ST_FAULT, 16'h07FF, 6'd0, 1'b0, 16'h0000, 16'hFFFF}};
    dir_tab[8]  = '{ROW_CHECK, OP_LOAD, 16'h0000, 6'd63, 16'hFFC5, 1'b0, NO_RES};
    dir_tab[9]  = '{ROW_CHECK, OP_WRITE, 16'h1555, 6'd0, 16'h0000, 1'b0,
                    '{ST_OK, 16'hFD55, 6'd0, 1'b0, 16'h0000, 16'h0000}};
    // shrink to one frame while the pointer sits at 2: next advance wraps
    dir_tab[10] = '{ROW_CFG, OP_READ, 16'h0000, 6'd0, 16'd1, REG_FRAME_COUNT, NO_RES};
    dir_tab[11] = '{ROW_CHECK, OP_READ, 16'h1C01, 6'd0, 16'h0000, 1'b0,
                    '{ST_FAULT, 16'h0801, 6'd0, 1'b0, 16'h0000, 16'hBEEF}};
    dir_tab[12] = '{ROW_CHECK, OP_READ, 16'h0400, 6'd0, 16'h0000, 1'b0,
                    '{ST_FAULT, 16'h0000, 6'd0, 1'b1, 16'hA5A5, 16'h0000}};
    dir_tab[13] = '{ROW_CHECK, OP_READ, 16'h0000, 6'd0, 16'h0000, 1'b0,
                    '{ST_FAULT, 16'h0000, 6'd1, 1'b0, 16'h0000, 16'hA5A5}};
    dir_tab[14] = '{ROW_CFG, OP_READ, 16'h0000, 6'd0, 16'd0, REG_PAGE_COUNT, NO_RES};
    dir_tab[15] = '{ROW_CHECK, OP_WRITE, 16'h0000, 6'd0, 16'h0000, 1'b0,
                    '{ST_RANGE, 16'h0000, 6'd0, 1'b0, 16'h0000, 16'h0000}};
    dir_tab[16] = '{ROW_CFG, OP_READ, 16'h0000, 6'd0, 16'd6, REG_PAGE_COUNT, NO_RES};
    dir_tab[17] = '{ROW_CHECK, OP_READ, 16'h17FF, 6'd0, 16'h0000, 1'b0,
                    '{ST_OK, 16'hFFFF, 6'd0, 1'b0, 16'h0000, 16'h0000}};
    dir_tab[18] = '{ROW_CHECK, OP_WRITE, 16'h1800, 6'd0, 16'h0000, 1'b0,
                    '{ST_RANGE, 16'h0000, 6'd0, 1'b0, 16'h0000, 16'h0000}};
    dir_tab[19] = '{ROW_CFG, OP_READ, 16'h0000, 6'd0, 16'd127, REG_PAGE_COUNT, NO_RES};
    dir_tab[20] = '{ROW_CFG, OP_READ, 16'h0000, 6'd0, 16'd127, REG_FRAME_COUNT, NO_RES};
    dir_tab[21] = '{ROW_CHECK, OP_READ, 16'hFC00, 6'd0, 16'h0000, 1'b0,
                    '{ST_OK, 16'h0400, 6'd0, 1'b0, 16'h0000, 16'h0000}};
    // loading frame 1 drops page 63 and moves page 0 away from frame 0
    dir_tab[22] = '{ROW_CHECK, OP_LOAD, 16'h0000, 6'd1, 16'h0000, 1'b0, NO_RES};
    dir_tab[23] = '{ROW_ITEM, OP_READ, 16'hFC00, 6'd0, 16'h0000, 1'b0, NO_RES};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == ROW_CFG) begin
        drain;
        cfg_write(dir_tab[r].cfg_reg, dir_tab[r].val[CFG_W-1:0]);
      end else begin
        send_item(dir_tab[r].op, dir_tab[r].addr, dir_tab[r].idx, dir_tab[r].val,
                  dir_tab[r].kind == ROW_CHECK, dir_tab[r].want);
      end
    end

    run_phase(7'd64, 7'd4, 180, 7, -1, -1);
    run_phase(7'd8, 7'd2, 180, 9, 90, -1);
    run_phase(7'd127, 7'd1, 170, 3, -1, -1);
    send_idle = 68;
    recv_idle = 14;
    run_phase(7'd40, 7'd64, 180, 63, -1, -1);
    run_phase(7'd0, 7'd3, 60, 5, -1, -1);
    run_phase(7'd17, 7'd0, 180, 20, -1, -1);
    send_idle = 0;
    recv_idle = 0;
    run_phase(7'd64, 7'd127, 200, 63, -1, 20);
    run_phase(7'd1, 7'd5, 100, 4, -1, -1);
    drain;

    if (errors == 0) begin
      $display("fifo_demand_paging_mmu_unit: match");
    end else begin
      $display("fifo_demand_paging_mmu_unit: mismatch");
    end
    $finish;
  end

endmodule
